### hdl/usd_pkg.sv
// Shared types, constants and lead-byte helpers for the UTF-8 stream decoder.
package usd_pkg;

   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 21;
   localparam int LEN_W    = 3;
   localparam int HELD_N   = 3;
   localparam int HELD_W   = 2;
   localparam int RES_N    = 4;
   localparam int RES_W    = 3;
   localparam int RIDX_W   = 2;

   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
   localparam logic [BYTE_W-1:0] PAY2_MASK  = 8'h1F;
   localparam logic [BYTE_W-1:0] PAY3_MASK  = 8'h0F;
   localparam logic [BYTE_W-1:0] PAY4_MASK  = 8'h07;
   localparam logic [BYTE_W-1:0] PAYC_MASK  = 8'h3F;

   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic advance;
   } usd_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic has_results;
      logic at_last;
   } usd_status_type;

   // Sequence length announced by a lead byte; stray bytes count as one
   function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] len;
      len = LEN_ONE;
      if ((b & LEAD2_MASK) == LEAD2_TAG) begin
         len = LEN_TWO;
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
         len = LEN_THREE;
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

   // Payload bits of a lead byte, zero-extended to a code point
   function automatic logic [CODE_W-1:0] lead_payload(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] bits;
      case (lead_length(b))
         LEN_TWO:   bits = b & PAY2_MASK;
         LEN_THREE: bits = b & PAY3_MASK;
         default:   bits = b & PAY4_MASK;
      endcase
      return {{(CODE_W-BYTE_W){1'b0}}, bits};
   endfunction

endpackage

### hdl/usd_ctrl.sv
// Controller: accepts one byte, then walks its results out one per transfer.
module usd_ctrl
   import usd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  usd_status_type status,
   output usd_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Handshake and command decode
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      rsp_valid   = (state_ff == ST_EMIT);
      cmd.load    = req_valid && (state_ff == ST_IDLE);
      cmd.advance = (state_ff == ST_EMIT) && !rsp_stall;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load && status.has_results) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.advance && status.at_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/usd_datapath.sv
// Datapath: sequence state, result list built per byte, and result readout.
module usd_datapath
   import usd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  usd_cmd_type         cmd,
   output usd_status_type      status,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_end_of_text,
   output logic [CODE_W-1:0]   rsp_code_point,
   output logic                rsp_run_last,
   output logic                rsp_text_last
);

   // Sequence state
   logic [LEN_W-1:0]  exp_ff,  exp_in;
   logic [HELD_W-1:0] cnt_ff,  cnt_in;
   logic [CODE_W-1:0] part_ff, part_in;
   logic [BYTE_W-1:0] held_ff [HELD_N];
   logic [BYTE_W-1:0] held_in [HELD_N];

   // Result list of the current byte
   logic [CODE_W-1:0] res_ff  [RES_N];
   logic [CODE_W-1:0] res_in  [RES_N];
   logic [RES_W-1:0]  rcnt_ff, rcnt_in;
   logic [RIDX_W-1:0] ridx_ff;
   logic              last_ff;

   logic              seq_open;
   logic              is_cont;
   logic [LEN_W-1:0]  new_len;
   logic [CODE_W-1:0] shifted;

   assign seq_open = (exp_ff > LEN_ONE) && (exp_ff <= LEN_FOUR);
   assign is_cont  = ((req_data_byte & CONT_MASK) == CONT_TAG);
   assign new_len  = lead_length(req_data_byte);
   assign shifted  = {part_ff[CODE_W-7:0], req_data_byte[5:0] & PAYC_MASK[5:0]};

   // Build the results of one byte and the state it leaves
   always_comb begin
      exp_in  = exp_ff;
      cnt_in  = cnt_ff;
      part_in = part_ff;
      rcnt_in = '0;
      for (int i = 0; i < HELD_N; i++) begin
         held_in[i] = held_ff[i];
      end
      for (int i = 0; i < RES_N; i++) begin
         res_in[i] = res_ff[i];
      end

      if (seq_open && is_cont) begin
         // Gather six more bits, finish or hold the byte
         part_in = shifted;
         if ({1'b0, cnt_ff} + 3'd2 >= exp_ff) begin
            res_in[rcnt_in[RIDX_W-1:0]] = shifted;
            rcnt_in = rcnt_in + 3'd1;
            exp_in  = LEN_ONE;
            cnt_in  = '0;
            part_in = '0;
         end else begin
            held_in[cnt_ff] = req_data_byte;
            cnt_in = cnt_ff + 2'd1;
         end
      end else begin
         if (seq_open) begin
            // Broken sequence: zero, then replay the held bytes
            res_in[rcnt_in[RIDX_W-1:0]] = '0;
            rcnt_in = rcnt_in + 3'd1;
            for (int i = 0; i < HELD_N; i++) begin
               if (HELD_W'(i) < cnt_ff) begin
                  res_in[rcnt_in[RIDX_W-1:0]] = {{(CODE_W-BYTE_W){1'b0}}, held_ff[i]};
                  rcnt_in = rcnt_in + 3'd1;
               end
            end
            cnt_in  = '0;
            part_in = '0;
         end
         // Handle the byte as a new lead
         exp_in = LEN_ONE;
         if (new_len == LEN_ONE) begin
            res_in[rcnt_in[RIDX_W-1:0]] = {{(CODE_W-BYTE_W){1'b0}}, req_data_byte};
            rcnt_in = rcnt_in + 3'd1;
         end else begin
            exp_in  = new_len;
            cnt_in  = '0;
            part_in = lead_payload(req_data_byte);
         end
      end

      // Truncated text: zero, then replay what is held
      if (req_end_of_text && (exp_in > LEN_ONE)) begin
         res_in[rcnt_in[RIDX_W-1:0]] = '0;
         rcnt_in = rcnt_in + 3'd1;
         for (int i = 0; i < HELD_N; i++) begin
            if (HELD_W'(i) < cnt_in) begin
               res_in[rcnt_in[RIDX_W-1:0]] = {{(CODE_W-BYTE_W){1'b0}}, held_in[i]};
               rcnt_in = rcnt_in + 3'd1;
            end
         end
         exp_in  = LEN_ONE;
         cnt_in  = '0;
         part_in = '0;
      end
   end

   // Update control state on load, advance readout on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= LEN_ONE;
         cnt_ff  <= '0;
         part_ff <= '0;
         rcnt_ff <= '0;
         ridx_ff <= '0;
      end else if (cmd.load) begin
         exp_ff  <= exp_in;
         cnt_ff  <= cnt_in;
         part_ff <= part_in;
         rcnt_ff <= rcnt_in;
         ridx_ff <= '0;
      end else if (cmd.advance) begin
         ridx_ff <= ridx_ff + 2'd1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         last_ff <= req_end_of_text;
         for (int i = 0; i < HELD_N; i++) begin
            held_ff[i] <= held_in[i];
         end
         for (int i = 0; i < RES_N; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign status.has_results = (rcnt_in != '0);
   assign status.at_last     = ({1'b0, ridx_ff} == (rcnt_ff - 3'd1));

   assign rsp_code_point = res_ff[ridx_ff];
   assign rsp_run_last   = status.at_last;
   assign rsp_text_last  = status.at_last && last_ff;

endmodule

### hdl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: controller plus datapath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   req     | in        | req_valid/req_stall| req_data_byte, req_end_of_text
//   rsp     | out       | rsp_valid/rsp_stall| rsp_code_point, rsp_run_last,
//           |           |                    | rsp_text_last
//
// A byte causes 0 to 4 results; the result list is walked out one transfer at a time.
// Synchronous active-high reset closes any open sequence and empties the list.
// A stall on rsp holds the current result; req is stalled until the list drains.
module utf8_stream_decoder
   import usd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_end_of_text,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_code_point,
   output logic              rsp_run_last,
   output logic              rsp_text_last
);

   usd_cmd_type    cmd;
   usd_status_type status;

   usd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   usd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_code_point  (rsp_code_point),
      .rsp_run_last    (rsp_run_last),
      .rsp_text_last   (rsp_text_last)
   );

endmodule
